>>> hdl/pesc_pkg.sv
package pesc_pkg;

  localparam int unsigned ROW_BITS = 6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_INIT,
    ST_SKIP,
    ST_EMIT,
    ST_TALL
  } state_e;

endpackage

>>> hdl/polygon_edge_scan_converter.sv
// polygon edge scan converter
// input channel (in_valid_i / in_ready_o): one edge per transfer, two
// endpoints plus the start-side and skip-first flags
// output channel (out_valid_o / out_ready_i): one x per scan line from
// y_begin up to but not including y_end, row_offset counting from 0 and
// last set on the final one
// an edge is taken only while the sequencer is idle; it then passes the
// height check, the bit-serial divider for width / height, a setup
// step, a skip step when skip_first is set, then gives one scan line
// per cycle as long as the receiver takes them
// zero-height and downward edges give no result, edges taller than
// MAX_ROWS give one result with too_tall set
// the result sits in an output register; a stalled receiver holds the
// walk, and the next edge can be taken while the last result still waits
// reset clears the sequencer and the output valid, no edge in flight
module polygon_edge_scan_converter #(
  parameter int unsigned MAX_ROWS   = 64,
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [COORD_BITS-1:0]          x_begin_i,
  input  logic signed [COORD_BITS-1:0]          y_begin_i,
  input  logic signed [COORD_BITS-1:0]          x_end_i,
  input  logic signed [COORD_BITS-1:0]          y_end_i,
  input  logic                                  to_start_side_i,
  input  logic                                  skip_first_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [COORD_BITS-1:0]          x_value_o,
  output logic [pesc_pkg::ROW_BITS-1:0]         row_offset_o,
  output logic                                  start_side_o,
  output logic                                  last_o,
  output logic                                  too_tall_o
);

  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned HW = $clog2(MAX_ROWS + 1);
  localparam int unsigned EW = HW + 1;
  localparam int unsigned XW = CB + 1;
  localparam int unsigned RB = pesc_pkg::ROW_BITS;

  pesc_pkg::state_e state_q, state_d;

  logic signed [CB-1:0] xb_q, xb_d;
  logic signed [XW-1:0] dx_q, dx_d;
  logic signed [XW-1:0] dy_q, dy_d;
  logic                 side_q, side_d;
  logic                 skip_q, skip_d;
  logic [HW-1:0]        h_q, h_d;
  logic signed [XW-1:0] x_q, x_d;
  logic signed [EW-1:0] err_q, err_d;
  logic [HW-1:0]        rows_q, rows_d;
  logic [RB-1:0]        n_q, n_d;

  logic                 out_valid_q, out_valid_d;
  logic signed [CB-1:0] ox_q, ox_d;
  logic [RB-1:0]        orow_q, orow_d;
  logic                 oside_q, oside_d;
  logic                 olast_q, olast_d;
  logic                 otall_q, otall_d;

  logic                 div_start;
  logic                 div_busy;
  logic [CB-1:0]        div_quot;
  logic [HW-1:0]        div_rem;
  logic [XW-1:0]        abs_dx;

  logic                 dir_pos;
  logic signed [EW-1:0] err_sum;
  logic                 carry;
  logic signed [EW-1:0] err_step;
  logic signed [XW:0]   major_ext;
  logic signed [XW:0]   dir_ext;
  logic signed [XW:0]   x_sum;
  logic signed [XW-1:0] x_step;
  logic                 out_free;
  logic                 in_xfer;

  assign abs_dx = dx_q[XW-1] ? (XW'(0) - dx_q) : dx_q;

  pesc_div #(
    .DW(CB),
    .VW(HW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(abs_dx[CB-1:0]),
    .divisor_i (dy_q[HW-1:0]),
    .busy_o    (div_busy),
    .quot_o    (div_quot),
    .rem_o     (div_rem)
  );

  // one row of the walk
  always_comb begin
    dir_pos   = dx_q > $signed(XW'(0));
    err_sum   = err_q + $signed({1'b0, div_rem});
    carry     = err_sum > $signed(EW'(0));
    err_step  = carry ? (err_sum - $signed({1'b0, h_q})) : err_sum;
    major_ext = dir_pos ? $signed({2'b00, div_quot}) : -$signed({2'b00, div_quot});
    dir_ext   = carry ? (dir_pos ? $signed((XW + 1)'(1)) : -$signed((XW + 1)'(1)))
                      : $signed((XW + 1)'(0));
    x_sum     = $signed({x_q[XW-1], x_q}) + major_ext + dir_ext;
    x_step    = x_sum[XW-1:0];
  end

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = state_q == pesc_pkg::ST_IDLE;
  assign in_xfer    = in_valid_i && in_ready_o;

  always_comb begin
    state_d     = state_q;
    xb_d        = xb_q;
    dx_d        = dx_q;
    dy_d        = dy_q;
    side_d      = side_q;
    skip_d      = skip_q;
    h_d         = h_q;
    x_d         = x_q;
    err_d       = err_q;
    rows_d      = rows_q;
    n_d         = n_q;
    div_start   = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    ox_d        = ox_q;
    orow_d      = orow_q;
    oside_d     = oside_q;
    olast_d     = olast_q;
    otall_d     = otall_q;
    case (state_q)
      pesc_pkg::ST_IDLE: begin
        if (in_xfer) begin
          xb_d    = x_begin_i;
          dx_d    = $signed({x_end_i[CB-1], x_end_i}) - $signed({x_begin_i[CB-1], x_begin_i});
          dy_d    = $signed({y_end_i[CB-1], y_end_i}) - $signed({y_begin_i[CB-1], y_begin_i});
          side_d  = to_start_side_i;
          skip_d  = skip_first_i;
          state_d = pesc_pkg::ST_CHECK;
        end
      end
      pesc_pkg::ST_CHECK: begin
        if (dy_q <= $signed(XW'(0))) begin
          state_d = pesc_pkg::ST_IDLE;
        end else if (dy_q > $signed(XW'(MAX_ROWS))) begin
          state_d = pesc_pkg::ST_TALL;
        end else begin
          h_d     = dy_q[HW-1:0];
          state_d = pesc_pkg::ST_DIV;
        end
      end
      pesc_pkg::ST_DIV: begin
        // divider is loaded on entry, then runs until idle again
        if (!div_busy) begin
          state_d = pesc_pkg::ST_INIT;
        end
      end
      pesc_pkg::ST_INIT: begin
        x_d     = $signed({xb_q[CB-1], xb_q});
        err_d   = (dx_q >= $signed(XW'(0))) ? $signed(EW'(0))
                                            : ($signed(EW'(1)) - $signed({1'b0, h_q}));
        rows_d  = h_q - HW'(skip_q);
        n_d     = '0;
        state_d = skip_q ? pesc_pkg::ST_SKIP : pesc_pkg::ST_EMIT;
      end
      pesc_pkg::ST_SKIP: begin
        x_d     = x_step;
        err_d   = err_step;
        state_d = (rows_q == '0) ? pesc_pkg::ST_IDLE : pesc_pkg::ST_EMIT;
      end
      pesc_pkg::ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          ox_d        = x_q[CB-1:0];
          orow_d      = n_q;
          oside_d     = side_q;
          olast_d     = rows_q == HW'(1);
          otall_d     = 1'b0;
          x_d         = x_step;
          err_d       = err_step;
          rows_d      = rows_q - HW'(1);
          n_d         = n_q + RB'(1);
          if (rows_q == HW'(1)) begin
            state_d = pesc_pkg::ST_IDLE;
          end
        end
      end
      pesc_pkg::ST_TALL: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          ox_d        = '0;
          orow_d      = '0;
          oside_d     = side_q;
          olast_d     = 1'b1;
          otall_d     = 1'b1;
          rows_d      = '0;
          state_d     = pesc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = pesc_pkg::ST_IDLE;
      end
    endcase
    if (state_q == pesc_pkg::ST_CHECK && state_d == pesc_pkg::ST_DIV) begin
      div_start = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pesc_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      rows_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      rows_q      <= rows_d;
    end
  end

  always_ff @(posedge clk_i) begin
    xb_q    <= xb_d;
    dx_q    <= dx_d;
    dy_q    <= dy_d;
    side_q  <= side_d;
    skip_q  <= skip_d;
    h_q     <= h_d;
    x_q     <= x_d;
    err_q   <= err_d;
    n_q     <= n_d;
    ox_q    <= ox_d;
    orow_q  <= orow_d;
    oside_q <= oside_d;
    olast_q <= olast_d;
    otall_q <= otall_d;
  end

  assign out_valid_o  = out_valid_q;
  assign x_value_o    = ox_q;
  assign row_offset_o = orow_q;
  assign start_side_o = oside_q;
  assign last_o       = olast_q;
  assign too_tall_o   = otall_q;

endmodule

>>> hdl/pesc_div.sv
module pesc_div #(
  parameter int unsigned DW = 16,
  parameter int unsigned VW = 7
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          busy_o,
  output logic [DW-1:0] quot_o,
  output logic [VW-1:0] rem_o
);

  localparam int unsigned CW = $clog2(DW + 1);

  logic [CW-1:0] cnt_q, cnt_d;
  logic [DW-1:0] quo_q, quo_d;
  logic [VW-1:0] rem_q, rem_d;
  logic [VW-1:0] dvs_q, dvs_d;
  logic [VW:0]   partial;
  logic [VW:0]   diff;
  logic          fits;

  // one quotient bit per cycle, restoring
  always_comb begin
    partial = {rem_q, quo_q[DW-1]};
    diff    = partial - {1'b0, dvs_q};
    fits    = partial >= {1'b0, dvs_q};
    cnt_d   = cnt_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    if (start_i) begin
      cnt_d = CW'(DW);
      quo_d = dividend_i;
      rem_d = '0;
      dvs_d = divisor_i;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - CW'(1);
      quo_d = {quo_q[DW-2:0], fits};
      rem_d = fits ? diff[VW-1:0] : partial[VW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign busy_o = cnt_q != '0;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

>>> hdl/pesc_checker.sv
module pesc_checker #(
  parameter int unsigned COORD_BITS = 16
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [COORD_BITS-1:0]         x_value_o,
  input logic [pesc_pkg::ROW_BITS-1:0] row_offset_o,
  input logic                          last_o,
  input logic                          too_tall_o
);

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(x_value_o) && $stable(row_offset_o))
    else $error("stalled result changed");

  // an accepted edge drops input ready in the cycle after the transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready right after a transfer");

  // a too-tall edge gives a single zero result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && too_tall_o |-> last_o && x_value_o == '0 && row_offset_o == '0)
    else $error("bad too_tall result");

  // no new edge while an edge still has lines to give
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> !in_ready_o)
    else $error("input ready in the middle of an edge");

endmodule

bind polygon_edge_scan_converter pesc_checker #(.COORD_BITS(COORD_BITS)) u_pesc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .x_value_o   (x_value_o),
  .row_offset_o(row_offset_o),
  .last_o      (last_o),
  .too_tall_o  (too_tall_o)
);

>>> dv/tb_polygon_edge_scan_converter.sv
module tb_polygon_edge_scan_converter;

  localparam int unsigned COORD_BITS  = 16;
  localparam int unsigned MAX_ROWS    = 64;
  localparam int unsigned NUM_RANDOM  = 95;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned DRAIN_LIMIT = 200000;
  localparam int unsigned TAIL_CYCLES = 200;

  typedef struct {
    logic signed [COORD_BITS-1:0]    x_value;
    logic [pesc_pkg::ROW_BITS-1:0]   row_offset;
    logic                            start_side;
    logic                            last;
    logic                            too_tall;
  } scan_x_t;

  class edge_scoreboard;
    scan_x_t     scan_x_q[$];
    int unsigned fail_cnt;

    function new();
      fail_cnt = 0;
    endfunction

    task report_mismatch(input string msg);
      $display("%0t: %s", $time, msg);
      fail_cnt++;
    endtask

    // walks the edge one scan line at a time with the integer error term
    function void note_edge(input logic signed [COORD_BITS-1:0] xb, yb, xe, ye,
                            input logic side, skip);
      longint  dx, dir, span, rows, quot, rem, err, cur;
      int      n;
      scan_x_t r;
      dx   = longint'(xe) - longint'(xb);
      dir  = (dx > 0) ? 1 : -1;
      span = (dx < 0) ? -dx : dx;
      rows = longint'(ye) - longint'(yb);
      if (rows <= 0) return;
      if (rows > MAX_ROWS) begin
        r.x_value    = '0;
        r.row_offset = '0;
        r.start_side = side;
        r.last       = 1'b1;
        r.too_tall   = 1'b1;
        scan_x_q.push_back(r);
        return;
      end
      quot = (span / rows) * dir;
      rem  = span % rows;
      err  = (dx >= 0) ? 0 : 1 - rows;
      cur  = longint'(xb);
      n    = 0;
      for (int i = 0; i < rows; i++) begin
        if (!(skip && i == 0)) begin
          r.x_value    = cur[COORD_BITS-1:0];
          r.row_offset = n[pesc_pkg::ROW_BITS-1:0];
          r.start_side = side;
          r.last       = (i == rows - 1);
          r.too_tall   = 1'b0;
          scan_x_q.push_back(r);
          n++;
        end
        cur += quot;
        err += rem;
        if (err > 0) begin
          cur += dir;
          err -= rows;
        end
      end
    endfunction

    task check_scan_x(input scan_x_t got);
      scan_x_t want;
      if (scan_x_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result x_value=%0d row_offset=%0d",
                                  got.x_value, got.row_offset));
        return;
      end
      want = scan_x_q.pop_front();
      if (got.x_value !== want.x_value)
        report_mismatch($sformatf("x_value got %0d expected %0d (row_offset %0d)",
                                  got.x_value, want.x_value, want.row_offset));
      if (got.row_offset !== want.row_offset)
        report_mismatch($sformatf("row_offset got %0d expected %0d",
                                  got.row_offset, want.row_offset));
      if (got.start_side !== want.start_side)
        report_mismatch($sformatf("start_side got %b expected %b",
                                  got.start_side, want.start_side));
      if (got.last !== want.last)
        report_mismatch($sformatf("last got %b expected %b (row_offset %0d)",
                                  got.last, want.last, want.row_offset));
      if (got.too_tall !== want.too_tall)
        report_mismatch($sformatf("too_tall got %b expected %b",
                                  got.too_tall, want.too_tall));
    endtask
  endclass

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          in_valid_i;
  logic                          in_ready_o;
  logic signed [COORD_BITS-1:0]  x_begin_i;
  logic signed [COORD_BITS-1:0]  y_begin_i;
  logic signed [COORD_BITS-1:0]  x_end_i;
  logic signed [COORD_BITS-1:0]  y_end_i;
  logic                          to_start_side_i;
  logic                          skip_first_i;
  logic                          out_valid_o;
  logic                          out_ready_i;
  logic signed [COORD_BITS-1:0]  x_value_o;
  logic [pesc_pkg::ROW_BITS-1:0] row_offset_o;
  logic                          start_side_o;
  logic                          last_o;
  logic                          too_tall_o;

  bit gap_on   = 1'b1;
  bit stall_on = 1'b1;
  bit hold_req = 1'b0;

  edge_scoreboard sb = new();

  polygon_edge_scan_converter #(
    .MAX_ROWS   (MAX_ROWS),
    .COORD_BITS (COORD_BITS)
  ) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .x_begin_i       (x_begin_i),
    .y_begin_i       (y_begin_i),
    .x_end_i         (x_end_i),
    .y_end_i         (y_end_i),
    .to_start_side_i (to_start_side_i),
    .skip_first_i    (skip_first_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .x_value_o       (x_value_o),
    .row_offset_o    (row_offset_o),
    .start_side_o    (start_side_o),
    .last_o          (last_o),
    .too_tall_o      (too_tall_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      sb.note_edge(x_begin_i, y_begin_i, x_end_i, y_end_i, to_start_side_i, skip_first_i);
    end
  end

  always @(posedge clk_i) begin : out_mon
    scan_x_t seen;
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen.x_value    = x_value_o;
      seen.row_offset = row_offset_o;
      seen.start_side = start_side_o;
      seen.last       = last_o;
      seen.too_tall   = too_tall_o;
      sb.check_scan_x(seen);
    end
  end

  // result side: random stall bursts and one long hold-off on request
  initial begin : sink
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk_i);
      end else if (stall_on && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 18) - 1) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic send_edge(input int xb, yb, xe, ye, input bit side, skip);
    if (gap_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    x_begin_i       <= xb[COORD_BITS-1:0];
    y_begin_i       <= yb[COORD_BITS-1:0];
    x_end_i         <= xe[COORD_BITS-1:0];
    y_end_i         <= ye[COORD_BITS-1:0];
    to_start_side_i <= side;
    skip_first_i    <= skip;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // mostly well-formed edges of modest height, some degenerate or too tall
  task automatic send_random_edge(output bit walks);
    int kind, rows, xb, xe, yb, ye;
    kind = $urandom_range(0, 99);
    rows = 1;
    xb   = int'($urandom_range(0, 65535)) - 32768;
    if ($urandom_range(0, 1))
      xe = int'($urandom_range(0, 65535)) - 32768;
    else
      xe = xb + int'($urandom_range(0, 400)) - 200;
    if (kind < 4) begin
      yb = int'($urandom_range(0, 65535)) - 32768;
      ye = yb;
    end else if (kind < 10) begin
      yb = int'($urandom_range(0, 65535)) - 32768;
      ye = int'($urandom_range(0, 65535)) - 32768;
    end else begin
      if (kind < 16)
        rows = $urandom_range(MAX_ROWS + 1, MAX_ROWS + 300);
      else if (kind < 84)
        rows = $urandom_range(1, 16);
      else
        rows = $urandom_range(17, MAX_ROWS);
      yb = int'($urandom_range(0, 65535 - rows)) - 32768;
      ye = yb + rows;
    end
    walks = (ye - yb > 0);
    send_edge(xb, yb, xe, ye, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  initial begin
    int unsigned made;
    int unsigned sent;
    int unsigned wait_cnt;
    bit          walks;
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    x_begin_i       = '0;
    y_begin_i       = '0;
    x_end_i         = '0;
    y_end_i         = '0;
    to_start_side_i = 1'b0;
    skip_first_i    = 1'b0;
    out_ready_i     = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero height, downward, single line, each slope class, extremes, too tall
    send_edge(0, 0, 0, 0, 1, 0);
    send_edge(10, 20, 30, 10, 0, 0);
    send_edge(32767, 32767, -32768, -32768, 1, 1);
    send_edge(5, 0, 5, 1, 1, 0);
    send_edge(5, 0, 9, 1, 0, 1);
    send_edge(100, -50, 100, -40, 0, 0);
    send_edge(100, -50, 100, -40, 1, 1);
    send_edge(0, 0, 8, 8, 1, 0);
    send_edge(0, 0, -8, 8, 0, 1);
    send_edge(3, 0, 7, 20, 1, 0);
    send_edge(3, 0, -4, 20, 0, 1);
    send_edge(10, -3, 0, 0, 1, 0);
    send_edge(0, 0, 1000, 7, 1, 0);
    send_edge(0, 0, -1000, 13, 0, 1);
    send_edge(-32768, 100, 32767, 164, 1, 0);
    send_edge(32767, -32768, -32768, -32704, 0, 1);
    send_edge(-32768, 32703, 32767, 32767, 0, 0);
    send_edge(-7, 1000, 25, 1065, 1, 0);
    send_edge(32767, -32768, -32768, 32767, 0, 1);
    send_edge(-1, -1, 1, 63, 1, 1);

    made = 0;
    sent = 0;
    while (made < NUM_RANDOM) begin
      if (sent == 40) hold_req = 1'b1;
      if (sent == 75) begin
        in_valid_i <= 1'b0;
        do @(posedge clk_i); while (sb.scan_x_q.size() != 0);
      end
      if (sent == 85) begin
        gap_on   = 1'b0;
        stall_on = 1'b0;
      end
      send_random_edge(walks);
      sent++;
      if (walks) made++;
    end
    in_valid_i <= 1'b0;

    wait_cnt = 0;
    do begin
      @(posedge clk_i);
      wait_cnt++;
    end while (sb.scan_x_q.size() != 0 && wait_cnt < DRAIN_LIMIT);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.scan_x_q.size() != 0)
      sb.report_mismatch($sformatf("%0d expected results never arrived", sb.scan_x_q.size()));
    if (sb.fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
